// ===== rtl/swq_pkg.sv =====
//------------------------------------------------------------------------------
// swq_pkg
// shared constants and types of the semaphore wait queue table
//------------------------------------------------------------------------------
package swq_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int NUM_PROCS = 16;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int PROC_W    = 4;
    localparam int KEY_W     = 32;

    localparam logic [1:0] CMD_BLOCK  = 2'd0;
    localparam logic [1:0] CMD_RMHEAD = 2'd1;
    localparam logic [1:0] CMD_RMPROC = 2'd2;
    localparam logic [1:0] CMD_PEEK   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFREE   = 2'd1;
    localparam logic [1:0] ST_BADARG   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // descriptor memory word: key, head, tail
    localparam int DESC_W = KEY_W + 2 * PROC_W;
    // process memory word: next, prev, descriptor index
    localparam int PROC_MW = 2 * PROC_W + SLOT_W;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [PROC_W-1:0] head;
        logic [PROC_W-1:0] tail;
    } desc_t;

    typedef struct packed {
        logic [PROC_W-1:0] next;
        logic [PROC_W-1:0] prev;
        logic [SLOT_W-1:0] didx;
    } pent_t;

endpackage

// ===== rtl/swq_ram.sv =====
//------------------------------------------------------------------------------
// swq_ram
// generic single port ram with registered read
//------------------------------------------------------------------------------
module swq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/semaphore_wait_queue_table.sv =====
//------------------------------------------------------------------------------
// semaphore_wait_queue_table
// table of semaphore descriptors each holding a fifo of blocked processes
//------------------------------------------------------------------------------
// usage:
//   input channel (valid/ready) carries command, key and proc_id; output
//   channel (out_valid/out_ready) returns status, proc_out, proc_valid, one
//   result per command transaction, in order.
//   one command is processed at a time. the key search reads the descriptor
//   ram one entry a cycle and stops at the first match, so a keyed command
//   finishes sooner when the key sits in a low entry; a rejected block goes
//   straight to the done state, and remove-process skips the search. in_ready
//   comes back as the result register is loaded, and the next command is
//   accepted from then on, even while that result waits. while the receiver
//   stalls with a result still held, a finished command waits in the done
//   state until it frees.
//   reset clears in-use and blocked bits (flip-flops); ram contents are
//   don't care until written, so no clearing pass is needed.
//------------------------------------------------------------------------------
module semaphore_wait_queue_table
    import swq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        command,
    input  logic [KEY_W-1:0]  key,
    input  logic [PROC_W-1:0] proc_id,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [PROC_W-1:0] proc_out,
    output logic              proc_valid
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SRCH   = 11'b00000000010,
        S_SCHK   = 11'b00000000100,
        S_DECIDE = 11'b00000001000,
        S_PRD    = 11'b00000010000,
        S_PWAIT  = 11'b00000100000,
        S_DRD    = 11'b00001000000,
        S_DWAIT  = 11'b00010000000,
        S_UNLINK = 11'b00100000000,
        S_LINK2  = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]        cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [PROC_W-1:0] pid_reg;
    logic [SLOT_W:0]   idx_reg;       // scan counter
    logic              found_reg;
    logic [SLOT_W-1:0] d_reg;
    desc_t             dent_reg;
    pent_t             pent_reg;      // entry of the process being unlinked
    logic [PROC_W-1:0] up_reg;        // process being unlinked
    logic [1:0]        st_reg;
    logic              pv_reg;
    logic [1:0]        step_reg;

    logic [NUM_SLOTS-1:0] in_use_reg;
    logic [NUM_PROCS-1:0] blocked_reg;

    logic              ov_reg;
    logic [1:0]        ost_reg;
    logic [PROC_W-1:0] opr_reg;
    logic              opv_reg;

    // ram ports
    logic              d_we, p_we;
    logic [SLOT_W-1:0] d_addr;
    logic [PROC_W-1:0] p_addr;
    desc_t             d_wdata, d_rdata;
    pent_t             p_wdata, p_rdata;

    swq_ram #(.WIDTH(DESC_W), .DEPTH(NUM_SLOTS)) u_desc_ram (
        .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata)
    );

    swq_ram #(.WIDTH(PROC_MW), .DEPTH(NUM_PROCS)) u_proc_ram (
        .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
    );

    // lowest free descriptor
    logic              any_free;
    logic [SLOT_W-1:0] free_idx;
    always_comb
    begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                any_free = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    logic out_free;
    assign out_free  = !ov_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign status    = ost_reg;
    assign proc_out  = opr_reg;
    assign proc_valid = opv_reg;

    logic [SLOT_W-1:0] sidx;
    assign sidx = idx_reg[SLOT_W-1:0];

    // unlink case flags, from head/tail of descriptor and the process being unlinked
    logic is_h, is_t;
    assign is_h = (up_reg == dent_reg.head);
    assign is_t = (up_reg == dent_reg.tail);

    always_comb
    begin
        state_next = state_reg;
        d_we = 1'b0;
        p_we = 1'b0;
        d_addr = d_reg;
        p_addr = up_reg;
        d_wdata = dent_reg;
        p_wdata = pent_reg;
        case (state_reg)
            S_IDLE:
            begin
                p_addr = proc_id;
                if (in_valid)
                begin
                    if (command == CMD_RMPROC)
                    begin
                        state_next = S_PWAIT;
                    end
                    else if (command == CMD_BLOCK && (key == '0 || blocked_reg[proc_id]))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH:
            begin
                d_addr = sidx;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                // data of entry idx_reg - 1 arrives now; next read issued
                d_addr = sidx;
                if (found_reg || idx_reg == (SLOT_W+1)'(NUM_SLOTS))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                if (cmd_reg == CMD_BLOCK)
                begin
                    if (!found_reg)
                    begin
                        if (any_free)
                        begin
                            d_we = 1'b1;
                            d_addr = free_idx;
                            d_wdata = '{key: key_reg, head: pid_reg, tail: pid_reg};
                            p_we = 1'b1;
                            p_addr = pid_reg;
                            p_wdata = '{next: '0, prev: '0, didx: free_idx};
                        end
                    end
                    else
                    begin
                        // append: new tail, then old tail's next link
                        d_we = 1'b1;
                        d_wdata.tail = pid_reg;
                        p_we = 1'b1;
                        p_addr = pid_reg;
                        p_wdata = '{next: '0, prev: dent_reg.tail, didx: d_reg};
                        state_next = S_PRD;
                    end
                end
                else if (found_reg && cmd_reg == CMD_RMHEAD)
                begin
                    p_addr = dent_reg.head;
                    state_next = S_DWAIT;
                end
            end
            S_PRD:
            begin
                // read old tail entry to patch its next link
                p_addr = dent_reg.tail;
                state_next = S_LINK2;
            end
            S_PWAIT:
            begin
                // process entry of proc_id arrives
                if (!blocked_reg[pid_reg] || !in_use_reg[p_rdata.didx])
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    d_addr = p_rdata.didx;
                    state_next = S_DRD;
                end
            end
            S_DRD:
            begin
                state_next = S_UNLINK;
            end
            S_DWAIT:
            begin
                state_next = S_UNLINK;
            end
            S_UNLINK:
            begin
                // dent_reg and pent_reg are valid
                state_next = S_DONE;
                if (is_h && is_t)
                begin
                end
                else if (is_h)
                begin
                    d_we = 1'b1;
                    d_wdata.head = pent_reg.next;
                end
                else if (is_t)
                begin
                    d_we = 1'b1;
                    d_wdata.tail = pent_reg.prev;
                end
                else
                begin
                    // step 0: read prev, 1: write prev.next, 2: read next
                    // 3: write next.prev
                    case (step_reg)
                        2'd0:
                        begin
                            p_addr = pent_reg.prev;
                            state_next = S_UNLINK;
                        end
                        2'd1:
                        begin
                            p_we = 1'b1;
                            p_addr = pent_reg.prev;
                            p_wdata = p_rdata;
                            p_wdata.next = pent_reg.next;
                            state_next = S_UNLINK;
                        end
                        2'd2:
                        begin
                            p_addr = pent_reg.next;
                            state_next = S_UNLINK;
                        end
                        default:
                        begin
                            p_we = 1'b1;
                            p_addr = pent_reg.next;
                            p_wdata = p_rdata;
                            p_wdata.prev = pent_reg.prev;
                        end
                    endcase
                end
            end
            S_LINK2:
            begin
                p_we = 1'b1;
                p_addr = dent_reg.tail;
                p_wdata = p_rdata;
                p_wdata.next = pid_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            in_use_reg  <= '0;
            blocked_reg <= '0;
            ov_reg      <= 1'b0;
            found_reg   <= 1'b0;
            idx_reg     <= '0;
            step_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        step_reg  <= '0;
                    end
                end
                S_SRCH:
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                S_SCHK:
                begin
                    if (!found_reg)
                    begin
                        if (in_use_reg[sidx - 1'b1] && d_rdata.key == key_reg)
                        begin
                            found_reg <= 1'b1;
                        end
                        else if (idx_reg != (SLOT_W+1)'(NUM_SLOTS))
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                S_DECIDE:
                begin
                    if (cmd_reg == CMD_BLOCK && (found_reg || any_free))
                    begin
                        blocked_reg[pid_reg] <= 1'b1;
                        if (!found_reg)
                        begin
                            in_use_reg[free_idx] <= 1'b1;
                        end
                    end
                end
                S_UNLINK:
                begin
                    if (!is_h && !is_t && step_reg != 2'd3)
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                    if (is_h && is_t)
                    begin
                        in_use_reg[d_reg] <= 1'b0;
                    end
                    if (state_next == S_DONE)
                    begin
                        blocked_reg[up_reg] <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cmd_reg <= command;
                key_reg <= key;
                pid_reg <= proc_id;
                up_reg  <= proc_id;
                st_reg  <= (command == CMD_BLOCK) ? ST_BADARG : ST_NOTFOUND;
                pv_reg  <= 1'b0;
            end
            S_SCHK:
            begin
                if (!found_reg && in_use_reg[sidx - 1'b1] && d_rdata.key == key_reg)
                begin
                    d_reg    <= sidx - 1'b1;
                    dent_reg <= d_rdata;
                end
            end
            S_DECIDE:
            begin
                if (cmd_reg == CMD_BLOCK)
                begin
                    st_reg <= (found_reg || any_free) ? ST_OK : ST_NOFREE;
                end
                else if (found_reg)
                begin
                    st_reg <= ST_OK;
                    pv_reg <= 1'b1;
                    up_reg <= dent_reg.head;
                end
            end
            S_PWAIT:
            begin
                pent_reg <= p_rdata;
                d_reg    <= p_rdata.didx;
                if (blocked_reg[pid_reg] && in_use_reg[p_rdata.didx])
                begin
                    st_reg <= ST_OK;
                    pv_reg <= 1'b1;
                end
            end
            S_DRD:
            begin
                // descriptor of the owning queue arrives
                dent_reg <= d_rdata;
            end
            S_DWAIT:
            begin
                pent_reg <= p_rdata;
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_DONE && out_free)
        begin
            ost_reg <= st_reg;
            opr_reg <= pv_reg ? up_reg : '0;
            opv_reg <= pv_reg;
        end
    end

    // assertions
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");
    a_pv_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && proc_valid) |-> status == ST_OK)
        else $error("process returned with error status");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> out_valid)
        else $error("finished command lost");

endmodule
